>>> src/mwrd_pkg.sv
// Package for the MMIO window route decoder.
// Holds sizes, codes, configuration and queue record types used by all modules.
`default_nettype none

package mwrd_pkg;

  localparam int unsigned ROUTE_COUNT = 4;
  localparam int unsigned ROUTE_REGS  = 4;
  localparam int unsigned LOG_ENTRIES = 16;
  localparam int unsigned LOG_IDX_W   = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
  localparam int unsigned LOG_USED_W  = $clog2(LOG_ENTRIES + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_BASE   = 3'd0,
    REG_WINDOW_BYTES  = 3'd1,
    REG_LENIENT_MODE  = 3'd2,
    REG_UNKNOWN_VALUE = 3'd3,
    REG_ROUTE_ZERO    = 3'd4,
    REG_ROUTE_ONE     = 3'd5,
    REG_ROUTE_TWO     = 3'd6,
    REG_ROUTE_THREE   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OUT_ROUTED         = 2'd0,
    OUT_OUTSIDE        = 2'd1,
    OUT_UNKNOWN_FAULT  = 2'd2,
    OUT_UNKNOWN_LOGGED = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_COMMIT = 3'b100
  } back_state_e;

  typedef struct packed {
    logic [31:0]                 window_base;
    logic [31:0]                 window_bytes;
    logic                        lenient_mode;
    logic [63:0]                 unknown_value;
    logic [ROUTE_REGS-1:0][63:0] route;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    window_base:   32'd0,
    window_bytes:  32'd65536,
    lenient_mode:  1'b0,
    unknown_value: 64'd0,
    route:         '0
  };

  typedef struct packed {
    logic        kind;
    outcome_e    outcome;
    logic [1:0]  route_index;
    logic [31:0] local_offset;
    logic [63:0] forward_data;
    logic [63:0] read_data;
    logic [31:0] bus_address;
  } cmd_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [1:0]  route_index;
    logic [31:0] local_offset;
    logic [63:0] forward_data;
    logic [63:0] read_data;
    logic [31:0] bus_address;
    logic [31:0] logged_reads;
    logic [31:0] logged_writes;
    logic        log_full;
  } result_t;

  typedef struct packed {
    logic [LOG_USED_W-1:0] log_used;
  } back_status_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

>>> src/mwrd_in_if.sv
// Input channel interface carrying one bus access transaction.
// Standalone; no package dependency.
`default_nettype none

interface mwrd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] access_offset;
  logic [1:0]  size_code;
  logic [63:0] store_data;

  modport source (output valid, kind, access_offset, size_code, store_data, input ready);
  modport sink   (input valid, kind, access_offset, size_code, store_data, output ready);
endinterface

`default_nettype wire

>>> src/mwrd_out_if.sv
// Output channel interface carrying one decode result transaction.
// Standalone; no package dependency.
`default_nettype none

interface mwrd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [1:0]  route_index;
  logic [31:0] local_offset;
  logic [63:0] forward_data;
  logic [63:0] read_data;
  logic [31:0] bus_address;
  logic [31:0] logged_reads;
  logic [31:0] logged_writes;
  logic        log_full;

  modport source (output valid, outcome, route_index, local_offset, forward_data, read_data,
                  bus_address, logged_reads, logged_writes, log_full, input ready);
  modport sink   (input valid, outcome, route_index, local_offset, forward_data, read_data,
                  bus_address, logged_reads, logged_writes, log_full, output ready);
endinterface

`default_nettype wire

>>> src/mwrd_queue.sv
// Short queue of classified accesses between the front and back parts.
// Depends on mwrd_pkg.
`default_nettype none

module mwrd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  mwrd_pkg::cmd_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output mwrd_pkg::cmd_t  pop_data_o
);
  import mwrd_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/mwrd_front.sv
// Front part: checks the window fit, matches routes and classifies an access.
// Depends on mwrd_pkg.
`default_nettype none

module mwrd_front (
  input  mwrd_pkg::cfg_t  cfg_i,
  input  logic            kind_i,
  input  logic [31:0]     access_offset_i,
  input  logic [1:0]      size_code_i,
  input  logic [63:0]     store_data_i,
  output mwrd_pkg::cmd_t  cmd_o
);
  import mwrd_pkg::*;

  logic [3:0]             width;
  logic [32:0]            end_addr;
  logic [32:0]            route_limit [ROUTE_COUNT];
  logic [ROUTE_COUNT-1:0] hit;
  logic                   any_hit;
  logic [1:0]             sel;
  logic [31:0]            sel_off;
  logic                   fits;

  always_comb begin
    width    = 4'd1 << size_code_i;
    end_addr = {1'b0, access_offset_i} + 33'(width);
    fits     = (end_addr <= {1'b0, cfg_i.window_bytes});
    for (int r = 0; r < ROUTE_COUNT; r++) begin
      route_limit[r] = {1'b0, cfg_i.route[r][31:0]} + {1'b0, cfg_i.route[r][63:32]};
      hit[r]         = (cfg_i.route[r][63:32] != '0) &&
                       (access_offset_i >= cfg_i.route[r][31:0]) &&
                       (end_addr <= route_limit[r]);
    end
    any_hit = |hit;
    sel     = '0;
    for (int r = ROUTE_COUNT - 1; r >= 0; r--) begin
      if (hit[r]) begin
        sel = 2'(r);
      end
    end
    sel_off = cfg_i.route[sel][31:0];
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.kind        = kind_i;
    cmd_o.bus_address = cfg_i.window_base + access_offset_i;
    if (!fits) begin
      cmd_o.outcome = OUT_OUTSIDE;
    end else if (any_hit) begin
      cmd_o.outcome      = OUT_ROUTED;
      cmd_o.route_index  = sel;
      cmd_o.local_offset = access_offset_i - sel_off;
      cmd_o.forward_data = kind_i ? store_data_i : '0;
    end else if (!cfg_i.lenient_mode) begin
      cmd_o.outcome = OUT_UNKNOWN_FAULT;
    end else begin
      cmd_o.outcome   = OUT_UNKNOWN_LOGGED;
      cmd_o.read_data = kind_i ? '0 : cfg_i.unknown_value;
    end
  end

endmodule

`default_nettype wire

>>> src/mwrd_back.sv
// Back part: updates the sorted access log and holds the result register.
// Depends on mwrd_pkg.
`default_nettype none

module mwrd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  mwrd_pkg::cmd_t         cmd_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output mwrd_pkg::result_t      res_o,
  output mwrd_pkg::back_status_t status_o
);
  import mwrd_pkg::*;

  back_state_e           state_q, state_d;
  cmd_t                  cur_q;
  result_t               res_q, res_d;
  logic                  res_valid_q;
  logic [LOG_USED_W-1:0] used_q;
  logic [31:0]           addr_q   [LOG_ENTRIES];
  logic [31:0]           rd_cnt_q [LOG_ENTRIES];
  logic [31:0]           wr_cnt_q [LOG_ENTRIES];
  logic [31:0]           prev_addr [LOG_ENTRIES];
  logic [31:0]           prev_rd   [LOG_ENTRIES];
  logic [31:0]           prev_wr   [LOG_ENTRIES];
  logic                  found_q;
  logic [LOG_IDX_W-1:0]  hit_idx_q;
  logic [LOG_USED_W-1:0] pos_q;
  logic [LOG_ENTRIES-1:0] match, less;
  logic                  found;
  logic [LOG_IDX_W-1:0]  hit_idx;
  logic [LOG_USED_W-1:0] pos;
  logic                  out_free, take_direct, commit, full, insert;
  logic [31:0]           old_rd, old_wr, new_rd, new_wr;

  assign out_free    = !res_valid_q || res_ready_i;
  assign take_direct = (state_q == ST_IDLE) && cmd_valid_i &&
                       (cmd_i.outcome != OUT_UNKNOWN_LOGGED) && out_free;
  assign cmd_ready_o = (state_q == ST_IDLE) &&
                       ((cmd_i.outcome == OUT_UNKNOWN_LOGGED) || out_free);
  assign commit      = (state_q == ST_COMMIT) && out_free;
  assign full        = !found_q && (used_q == LOG_USED_W'(LOG_ENTRIES));
  assign insert      = commit && !found_q && !full;

  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    pos     = '0;
    for (int i = 0; i < LOG_ENTRIES; i++) begin
      match[i] = (LOG_USED_W'(i) < used_q) && (addr_q[i] == cur_q.bus_address);
      less[i]  = (LOG_USED_W'(i) < used_q) && (addr_q[i] < cur_q.bus_address);
      pos      = pos + LOG_USED_W'(less[i]);
      if (match[i]) begin
        found   = 1'b1;
        hit_idx = LOG_IDX_W'(i);
      end
    end
  end

  always_comb begin
    prev_addr[0] = cur_q.bus_address;
    prev_rd[0]   = '0;
    prev_wr[0]   = '0;
    for (int i = 1; i < LOG_ENTRIES; i++) begin
      prev_addr[i] = addr_q[i-1];
      prev_rd[i]   = rd_cnt_q[i-1];
      prev_wr[i]   = wr_cnt_q[i-1];
    end
    old_rd = found_q ? rd_cnt_q[hit_idx_q] : '0;
    old_wr = found_q ? wr_cnt_q[hit_idx_q] : '0;
    new_rd = cur_q.kind ? old_rd : sat_inc(old_rd);
    new_wr = cur_q.kind ? sat_inc(old_wr) : old_wr;
  end

  always_comb begin
    res_d = '0;
    if (take_direct) begin
      res_d.outcome      = cmd_i.outcome;
      res_d.route_index  = cmd_i.route_index;
      res_d.local_offset = cmd_i.local_offset;
      res_d.forward_data = cmd_i.forward_data;
      res_d.bus_address  = cmd_i.bus_address;
    end else begin
      res_d.outcome       = OUT_UNKNOWN_LOGGED;
      res_d.read_data     = cur_q.read_data;
      res_d.bus_address   = cur_q.bus_address;
      res_d.logged_reads  = full ? '0 : new_rd;
      res_d.logged_writes = full ? '0 : new_wr;
      res_d.log_full      = full;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.outcome == OUT_UNKNOWN_LOGGED)) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      used_q      <= '0;
    end else begin
      state_q <= state_d;
      if (take_direct || commit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (insert) begin
        used_q <= used_q + LOG_USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && cmd_valid_i) begin
      cur_q <= cmd_i;
    end
    if (state_q == ST_SEARCH) begin
      found_q   <= found;
      hit_idx_q <= hit_idx;
      pos_q     <= pos;
    end
    if (take_direct || commit) begin
      res_q <= res_d;
    end
    for (int i = 0; i < LOG_ENTRIES; i++) begin
      if (commit && found_q && (LOG_IDX_W'(i) == hit_idx_q)) begin
        rd_cnt_q[i] <= new_rd;
        wr_cnt_q[i] <= new_wr;
      end else if (insert && (LOG_USED_W'(i) == pos_q)) begin
        addr_q[i]   <= cur_q.bus_address;
        rd_cnt_q[i] <= new_rd;
        wr_cnt_q[i] <= new_wr;
      end else if (insert && (LOG_USED_W'(i) > pos_q) && (LOG_USED_W'(i) <= used_q)) begin
        addr_q[i]   <= prev_addr[i];
        rd_cnt_q[i] <= prev_rd[i];
        wr_cnt_q[i] <= prev_wr[i];
      end
    end
  end

  assign res_valid_o       = res_valid_q;
  assign res_o             = res_q;
  assign status_o.log_used = used_q;

endmodule

`default_nettype wire

>>> src/mmio_window_route_decoder.sv
// Top level of the MMIO window route decoder: configuration registers and wiring.
// Depends on mwrd_pkg, mwrd_in_if, mwrd_out_if, mwrd_queue, mwrd_front and mwrd_back.
//
// Each access is classified in the cycle it is accepted and queued for the back end,
// which holds a registered result. Routed and faulting accesses leave the back end at
// one per cycle while the output is not stalled; a lenient unknown access goes through
// dequeue, table search, and sorted insert or counter update there, and the back end
// takes no new access until it is done with it. The log keeps up to sixteen addresses;
// when it is full, new addresses are reported with log_full set and are not recorded.
`default_nettype none

module mmio_window_route_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mwrd_in_if.sink                       in_i,
  mwrd_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [mwrd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                   cfg_wdata_i
);
  import mwrd_pkg::*;

  cfg_t         cfg_q, cfg_d;
  cmd_t         front_cmd, queue_cmd;
  logic         q_valid, q_ready;
  result_t      res;
  back_status_t status;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WINDOW_BASE:   cfg_d.window_base   = cfg_wdata_i[31:0];
        REG_WINDOW_BYTES:  cfg_d.window_bytes  = cfg_wdata_i[31:0];
        REG_LENIENT_MODE:  cfg_d.lenient_mode  = cfg_wdata_i[0];
        REG_UNKNOWN_VALUE: cfg_d.unknown_value = cfg_wdata_i;
        REG_ROUTE_ZERO:    cfg_d.route[0]      = cfg_wdata_i;
        REG_ROUTE_ONE:     cfg_d.route[1]      = cfg_wdata_i;
        REG_ROUTE_TWO:     cfg_d.route[2]      = cfg_wdata_i;
        REG_ROUTE_THREE:   cfg_d.route[3]      = cfg_wdata_i;
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mwrd_front u_front (
    .cfg_i           (cfg_q),
    .kind_i          (in_i.kind),
    .access_offset_i (in_i.access_offset),
    .size_code_i     (in_i.size_code),
    .store_data_i    (in_i.store_data),
    .cmd_o           (front_cmd)
  );

  mwrd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_i.valid),
    .push_ready_o (in_i.ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (queue_cmd)
  );

  mwrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (queue_cmd),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready),
    .res_o       (res),
    .status_o    (status)
  );

  assign out_o.outcome       = res.outcome;
  assign out_o.route_index   = res.route_index;
  assign out_o.local_offset  = res.local_offset;
  assign out_o.forward_data  = res.forward_data;
  assign out_o.read_data     = res.read_data;
  assign out_o.bus_address   = res.bus_address;
  assign out_o.logged_reads  = res.logged_reads;
  assign out_o.logged_writes = res.logged_writes;
  assign out_o.log_full      = res.log_full;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.log_used <= LOG_USED_W'(LOG_ENTRIES))
    else $error("log fill count exceeds table size");

  a_used_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> status.log_used >= $past(status.log_used))
    else $error("log fill count decreased");

  a_logged_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.outcome == OUT_UNKNOWN_LOGGED) && !out_o.log_full)
      |-> (out_o.logged_reads != '0 || out_o.logged_writes != '0))
    else $error("logged transaction reported with both counters zero");

endmodule

`default_nettype wire
